// ===== sv/agc_pkg.sv =====
// Shared widths, constants, register indexes and sequencer states for the audio AGC.
package agc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int ENV_W     = COEF_W;
  localparam int GAIN_W    = 32;
  localparam int TGT_W     = 15;
  localparam int LIMIT_W   = 16;
  localparam int PROD_W    = COEF_W + GAIN_W;
  localparam int QUOT_W    = GAIN_W;
  localparam int CFG_W     = COEF_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [ENV_W-1:0]  ENV_FLOOR = ENV_W'(((64'd1 << (ENV_W - 1)) + 64'd5000) / 64'd10000);
  localparam logic [ENV_W-1:0]  ENV_ONE   = ENV_W'(64'd1 << (ENV_W - 1));
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(64'd1 << COEF_W);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (COEF_W - 1));

  localparam logic               RST_ENABLE  = 1'b1;
  localparam logic [COEF_W-1:0]  RST_ATTACK  = COEF_W'(345600);
  localparam logic [COEF_W-1:0]  RST_RELEASE = COEF_W'(1748);
  localparam logic [TGT_W-1:0]   RST_TARGET  = TGT_W'(16384);
  localparam logic [LIMIT_W-1:0] RST_LIMIT   = LIMIT_W'(2560);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_DIFF,
    S_ENV_MUL,
    S_ENV_UPD,
    S_DIV_START,
    S_DIV_WAIT,
    S_GAIN_DIFF,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_OUT_MUL,
    S_OUT
  } agc_state_t;

endpackage

// ===== sv/audio_agc.sv =====
// Audio AGC top level: attack/release envelope, divided target gain, smoothed gain, output scale.
//
//  port group  dir  beat contents
//  in_*        in   in_tdata[15:0] sample_in
//  out_*       out  out_tdata[15:0] sample_out, [31:16] gain_now
//  cfg_*       in   cfg_index register index, cfg_data value (low bits used)
//
//  An enabled sample waits on the 32-step divider between input beats, except when the quotient
//  would reach 2^32 and the divide is skipped.
//  One 24x32 multiplier serves the envelope, gain and output products in turn.
//  A disabled sample goes from the idle state straight to the output state. Reset is synchronous and active low.
//  A finished beat waits in the output register while the next sample is taken;
//  the sequencer stalls in its last state only when that register is still full.
module audio_agc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] sample_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [15:0] sample_out, [31:16] gain_now
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [agc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [agc_pkg::CFG_W-1:0]       cfg_data
);
  import agc_pkg::*;

  // configuration
  logic                enable_r;
  logic [COEF_W-1:0]   attack_r;
  logic [COEF_W-1:0]   release_r;
  logic [TGT_W-1:0]    target_r;
  logic [LIMIT_W-1:0]  limit_r;

  // sequencer and datapath
  agc_state_t          state_r, state_nxt;
  logic [ENV_W-1:0]    env_r, env_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [GAIN_W-1:0]   diff_r, diff_nxt;
  logic [COEF_W-1:0]   coeff_r, coeff_nxt;
  logic                up_r, up_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [GAIN_W-1:0]   desired_r, desired_nxt;
  logic [SAMPLE_W-1:0] mag_r, mag_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                neg_r, neg_nxt;
  logic                bypass_r, bypass_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_data_r, out_data_nxt;

  logic                in_beat;
  logic [ENV_W-1:0]    mag_env;
  logic [ENV_W-1:0]    env_clamped;
  logic [ENV_W-1:0]    tgt_env;
  logic [GAIN_W-1:0]   limit_q;
  logic [COEF_W-1:0]   mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [PROD_W-1:0]   rounded;
  logic [GAIN_W-1:0]   step;
  logic [SAMPLE_W-1:0] sat_val;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= RST_ENABLE;
      attack_r  <= RST_ATTACK;
      release_r <= RST_RELEASE;
      target_r  <= RST_TARGET;
      limit_r   <= RST_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:  enable_r  <= cfg_data[0];
        REG_ATTACK:  attack_r  <= cfg_data[COEF_W-1:0];
        REG_RELEASE: release_r <= cfg_data[COEF_W-1:0];
        REG_TARGET:  target_r  <= cfg_data[TGT_W-1:0];
        REG_LIMIT:   limit_r   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  assign mag_env     = {mag_r, {(ENV_W-SAMPLE_W){1'b0}}};
  assign env_clamped = (env_r > ENV_FLOOR) ? env_r : ENV_FLOOR;
  assign tgt_env     = {1'b0, target_r, {(ENV_W-TGT_W-1){1'b0}}};
  assign limit_q     = {limit_r, {(GAIN_W-LIMIT_W){1'b0}}};

  // shared multiplier: coefficient times distance, or magnitude times gain
  assign mul_a = (state_r == S_OUT_MUL) ? COEF_W'(mag_r) : coeff_r;
  assign mul_b = (state_r == S_OUT_MUL) ? gain_r : diff_r;

  assign rounded = prod_r + ROUND_HALF;
  assign step    = rounded[PROD_W-1:COEF_W];

  always_comb begin
    if (neg_r) begin
      sat_val = (step > GAIN_W'(32768)) ? 16'h8000 : SAMPLE_W'(-step);
    end else begin
      sat_val = (step > GAIN_W'(32767)) ? 16'h7FFF : step[SAMPLE_W-1:0];
    end
  end

  agc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tgt_env),
    .den   (env_clamped),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    env_nxt       = env_r;
    gain_nxt      = gain_r;
    diff_nxt      = diff_r;
    coeff_nxt     = coeff_r;
    up_nxt        = up_r;
    prod_nxt      = prod_r;
    desired_nxt   = desired_r;
    mag_nxt       = mag_r;
    sample_nxt    = sample_r;
    neg_nxt       = neg_r;
    bypass_nxt    = bypass_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          sample_nxt = in_tdata;
          neg_nxt    = in_tdata[SAMPLE_W-1];
          mag_nxt    = in_tdata[SAMPLE_W-1] ? SAMPLE_W'(-in_tdata) : in_tdata;
          bypass_nxt = !enable_r;
          state_nxt  = enable_r ? S_ENV_DIFF : S_OUT;
        end
      end
      S_ENV_DIFF: begin
        up_nxt    = (mag_env >= env_r);
        coeff_nxt = (mag_env > env_r) ? attack_r : release_r;
        diff_nxt  = (mag_env >= env_r) ? GAIN_W'(mag_env - env_r) : GAIN_W'(env_r - mag_env);
        state_nxt = S_ENV_MUL;
      end
      S_ENV_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        env_nxt   = up_r ? env_r + step[ENV_W-1:0] : env_r - step[ENV_W-1:0];
        state_nxt = S_DIV_START;
      end
      S_DIV_START: begin
        // quotient of 2^32 or more is above any limit: skip the divide
        if ({8'b0, tgt_env} >= {env_clamped, 8'b0}) begin
          desired_nxt = limit_q;
          state_nxt   = S_GAIN_DIFF;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          desired_nxt = (div_quot > limit_q) ? limit_q : div_quot;
          state_nxt   = S_GAIN_DIFF;
        end
      end
      S_GAIN_DIFF: begin
        up_nxt    = (desired_r >= gain_r);
        coeff_nxt = release_r;
        diff_nxt  = (desired_r >= gain_r) ? desired_r - gain_r : gain_r - desired_r;
        state_nxt = S_GAIN_MUL;
      end
      S_GAIN_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_GAIN_UPD;
      end
      S_GAIN_UPD: begin
        gain_nxt  = up_r ? gain_r + step : gain_r - step;
        state_nxt = S_OUT_MUL;
      end
      S_OUT_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {gain_r[GAIN_W-1:GAIN_W-16], bypass_r ? sample_r : sat_val};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      env_r       <= '0;
      gain_r      <= GAIN_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      env_r       <= env_nxt;
      gain_r      <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    coeff_r    <= coeff_nxt;
    up_r       <= up_nxt;
    prod_r     <= prod_nxt;
    desired_r  <= desired_nxt;
    mag_r      <= mag_nxt;
    sample_r   <= sample_nxt;
    neg_r      <= neg_nxt;
    bypass_r   <= bypass_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n) env_r <= ENV_ONE)
    else $error("envelope above full scale");
  a_desired_cap: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_GAIN_DIFF |-> desired_r <= limit_q)
    else $error("desired gain above limit");
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
      div_done |-> state_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("output beat raised outside the output state");
  a_bypass_state: assert property (@(posedge clk) disable iff (!rst_n)
      in_beat && !enable_r |=> state_r == S_OUT)
    else $error("disabled sample entered the gain path");

endmodule

// ===== sv/agc_div.sv =====
// Restoring divider, one quotient bit a cycle: quot = floor((num << 24) / den).
module agc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [agc_pkg::ENV_W-1:0]     num,
  input  logic [agc_pkg::ENV_W-1:0]     den,
  output logic                          done,
  output logic [agc_pkg::QUOT_W-1:0]    quot
);
  import agc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);
  localparam int LO_W  = ENV_W + QUOT_W - ENV_W; // low dividend bits still to shift in

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ENV_W-1:0]    rem_r;
  logic [ENV_W-1:0]    den_r;
  logic [LO_W-1:0]     nlo_r;
  logic [QUOT_W-1:0]   quot_r;

  logic [ENV_W:0]      rem_sh;
  logic [ENV_W+1:0]    trial;
  logic                qbit;
  logic [ENV_W-1:0]    rem_nxt;

  // Caller guarantees the quotient fits, so the top dividend bits are below den.
  always_comb begin
    rem_sh  = {rem_r, nlo_r[LO_W-1]};
    trial   = {1'b0, rem_sh} - {2'b0, den_r};
    qbit    = ~trial[ENV_W+1];
    rem_nxt = qbit ? trial[ENV_W-1:0] : rem_sh[ENV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= ENV_W'(num[ENV_W-1:8]);
      nlo_r  <= {num[7:0], {(LO_W-8){1'b0}}};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      nlo_r  <= {nlo_r[LO_W-2:0], 1'b0};
      quot_r <= {quot_r[QUOT_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held for two cycles");

endmodule

// ===== verif/tb_audio_agc.sv =====
// Self-checking testbench for audio_agc: directed table, random audio segments, stream checks.
module tb_audio_agc;
  import agc_pkg::*;

  localparam int  N_ROWS      = 31;
  localparam int  RAND_ITEMS  = 1350;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  LONG_HOLD   = 300;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [63:0] Q24_HALF = 64'd1 << 23;

  typedef struct packed {
    logic [15:0] gain_now;
    logic [15:0] sample_out;
  } agc_beat_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [15:0]          smp;
    logic                 typed;
    logic [15:0]          exp_out;
    logic [15:0]          exp_gain;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata  = '0;   // [15:0] sample_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;        // [15:0] sample_out, [31:16] gain_now
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // predictor registers and state
  logic               en_r      = RST_ENABLE;
  logic [COEF_W-1:0]  attack_r  = RST_ATTACK;
  logic [COEF_W-1:0]  release_r = RST_RELEASE;
  logic [TGT_W-1:0]   target_r  = RST_TARGET;
  logic [LIMIT_W-1:0] limit_r   = RST_LIMIT;
  logic [ENV_W-1:0]   env_q     = '0;
  logic [GAIN_W-1:0]  gain_q    = GAIN_ONE;

  agc_beat_t beats_due[$];
  int        mismatches  = 0;
  int        tx_sent     = 0;
  bit        tx_calm     = 1'b0;
  int        hold_ask    = 0;
  int        cycle_count = 0;

  // disabled rows and the first enabled silent row are typed in; the rest are predicted
  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_WRITE,  REG_ENABLE,  24'hFFFFFE, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h7FFF, 1'b1, 16'h7FFF, 16'h0100},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h8000, 1'b1, 16'h8000, 16'h0100},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h0000, 1'b1, 16'h0000, 16'h0100},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'hFFFF, 1'b1, 16'hFFFF, 16'h0100},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h5555, 1'b1, 16'h5555, 16'h0100},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'hAAAA, 1'b1, 16'hAAAA, 16'h0100},
    '{ROW_WRITE,  REG_ENABLE,  24'h000001, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h0000, 1'b1, 16'h0000, 16'h0100},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_NONE,    24'hFFFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h4000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_LIMIT,   24'h000000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h1234, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_LIMIT,   24'hFFFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_ATTACK,  24'hFFFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_RELEASE, 24'hFFFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_TARGET,  24'hFFFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_ATTACK,  24'h000000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_RELEASE, 24'h000000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_TARGET,  24'h000000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,    24'h0,      16'h8001, 1'b0, 16'h0000, 16'h0000},
    '{ROW_WRITE,  REG_TARGET,  24'h004000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
  };

  audio_agc u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL audio_agc");
      $finish;
    end
  end

  // one-pole move towards goal, step rounded half up so it never overshoots
  function automatic logic [63:0] one_pole(input logic [63:0] x, input logic [63:0] goal,
                                           input logic [63:0] wt);
    if (goal >= x)
      return x + ((wt * (goal - x) + Q24_HALF) >> 24);
    else
      return x - ((wt * (x - goal) + Q24_HALF) >> 24);
  endfunction

  function automatic agc_beat_t gained_beat(input logic [15:0] smp);
    logic [63:0] mag, goal, wt, floored, want_gain, cap, scaled;
    agc_beat_t   beat;
    mag = smp[15] ? 64'd65536 - 64'(smp) : 64'(smp);
    beat.gain_now   = gain_q[31:16];
    beat.sample_out = smp;
    if (!en_r)
      return beat;
    goal    = mag << 8;
    wt      = (goal > 64'(env_q)) ? 64'(attack_r) : 64'(release_r);
    env_q   = ENV_W'(one_pole(64'(env_q), goal, wt));
    floored = (env_q > ENV_FLOOR) ? 64'(env_q) : 64'(ENV_FLOOR);
    want_gain = (64'(target_r) << 32) / floored;
    cap       = 64'(limit_r) << 16;
    if (want_gain > cap)
      want_gain = cap;
    want_gain = one_pole(64'(gain_q), want_gain, 64'(release_r));
    gain_q    = (want_gain > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : want_gain[31:0];
    scaled    = (mag * 64'(gain_q) + Q24_HALF) >> 24;
    if (smp[15])
      beat.sample_out = (scaled > 64'd32768) ? 16'h8000 : 16'(64'd0 - scaled);
    else
      beat.sample_out = (scaled > 64'd32767) ? 16'h7FFF : scaled[15:0];
    beat.gain_now = gain_q[31:16];
    return beat;
  endfunction

  function automatic logic [COEF_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return COEF_W'($urandom);
      3:       return COEF_W'($urandom_range(1, 4096));
      default: return COEF_W'($urandom_range(4096, 1 << 21));
    endcase
  endfunction

  // mostly band-limited to the segment amplitude, with some full-range noise and extremes
  function automatic logic [15:0] audio_sample(input int amp);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom_range(0, 2 * amp - 1) - amp);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:  en_r      = data[0];
      REG_ATTACK:  attack_r  = data;
      REG_RELEASE: release_r = data;
      REG_TARGET:  target_r  = data[TGT_W-1:0];
      REG_LIMIT:   limit_r   = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic typed,
                             input agc_beat_t typed_beat);
    int        gap;
    agc_beat_t beat;
    if (tx_sent % 40 == 0)
      tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    beat = gained_beat(smp);
    beats_due.insert(beats_due.size(), typed ? typed_beat : beat);
    tx_sent++;
  endtask

  // drop valid and hold until every outstanding beat has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  initial begin : beat_sink
    int        stall;
    int        got_n     = 0;
    int        hold_seen = 0;
    bit        rx_calm   = 1'b0;
    agc_beat_t got;
    agc_beat_t want;
    forever begin
      if (got_n % 40 == 0)
        rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        stall = LONG_HOLD;
      end else
        stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      got_n++;
      if (beats_due.size() == 0) begin
        $error("sample_out: expected no beat, actual %h (gain_now %h)",
               got.sample_out, got.gain_now);
        mismatches++;
      end else begin
        want = beats_due.pop_front();
        if (got.sample_out !== want.sample_out) begin
          $error("sample_out: expected %h, actual %h", want.sample_out, got.sample_out);
          mismatches++;
        end
        if (got.gain_now !== want.gain_now) begin
          $error("gain_now: expected %h, actual %h", want.gain_now, got.gain_now);
          mismatches++;
        end
      end
    end
  end

  initial begin : run
    int          rand_sent = 0;
    int          phase     = 0;
    int          phase_len;
    int          amp       = 1024;
    int          seg_left  = 0;
    int          pick;
    logic [15:0] lvl;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else
        send_sample(dir_rows[i].smp, dir_rows[i].typed,
                    {dir_rows[i].exp_gain, dir_rows[i].exp_out});
    end

    while (rand_sent < RAND_ITEMS) begin
      settle();
      // upper data bits are random to exercise the register masking
      write_reg(REG_ENABLE, {23'($urandom), ($urandom_range(0, 4) != 0)});
      write_reg(REG_ATTACK, pick_weight());
      write_reg(REG_RELEASE, pick_weight());
      pick = $urandom_range(0, 5);
      lvl  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd32767 : 16'($urandom_range(0, 32767));
      write_reg(REG_TARGET, {9'($urandom), lvl[TGT_W-1:0]});
      pick = $urandom_range(0, 5);
      lvl  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
             (pick == 2) ? 16'($urandom) : 16'($urandom_range(256, 4096));
      write_reg(REG_LIMIT, {8'($urandom), lvl});
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_NONE, COEF_W'($urandom));
      // back-pressure the output long enough for the input to stall
      if (phase == 2 || phase == 7)
        hold_ask++;
      phase_len = $urandom_range(60, 160);
      repeat (phase_len) begin
        if (seg_left == 0) begin
          amp      = 1 << $urandom_range(0, 15);
          seg_left = $urandom_range(16, 96);
        end
        seg_left--;
        send_sample(audio_sample(amp), 1'b0, '0);
        rand_sent++;
        if (phase == 5 && rand_sent % 50 == 0)
          settle();
      end
      phase++;
    end

    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("PASS audio_agc");
    else
      $display("FAIL audio_agc");
    $finish;
  end

endmodule
